### sv/sdfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sdfr_pkg;

  localparam int DATA_W = 8;
  localparam int POS_W  = 6;

  localparam logic [DATA_W-1:0] END_MARKER_RST    = 8'h0a;
  localparam logic [DATA_W-1:0] SILENCE_TICKS_RST = 8'd100;
  localparam logic [DATA_W-1:0] SILENCE_SAT       = 8'hff;

  localparam logic CFG_END_MARKER    = 1'b0;
  localparam logic CFG_SILENCE_TICKS = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_e;

  typedef struct packed {
    logic              resync;
    logic              done;
    logic [DATA_W-1:0] data;
  } front_t;

endpackage
`default_nettype wire

### sv/sdfr_ring.sv
`timescale 1ns / 1ps
`default_nettype none
module sdfr_ring #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [sdfr_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [sdfr_pkg::DATA_W-1:0] rdata_o
);

  logic [sdfr_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### sv/sdfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sdfr_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic                        strobe_level_i,
  input  wire logic [1:0]                  data_pair_i,
  input  wire logic [sdfr_pkg::DATA_W-1:0] silence_ticks_i,
  output sdfr_pkg::front_t                 front_o
);

  logic [sdfr_pkg::DATA_W-1:0] silence_q, silence_d;
  logic                        prev_q;
  logic [1:0]                  pair_idx_q, pair_idx_d, pair_base;
  logic [sdfr_pkg::DATA_W-1:0] acc_q, acc_d, acc_base, acc_new;
  logic                        edge_seen;

  always_comb begin
    silence_d       = '0;
    front_o.resync  = 1'b0;
    if (strobe_level_i) begin
      silence_d      = (silence_q == sdfr_pkg::SILENCE_SAT) ? silence_q
                                                             : silence_q + 8'd1;
      front_o.resync = (silence_d == silence_ticks_i);
    end
    pair_base    = front_o.resync ? 2'd0 : pair_idx_q;
    acc_base     = front_o.resync ? '0 : acc_q;
    edge_seen    = (strobe_level_i != prev_q);
    acc_new      = acc_base | (sdfr_pkg::DATA_W'(data_pair_i) << {pair_base, 1'b0});
    front_o.done = edge_seen && (pair_base == 2'd3);
    front_o.data = acc_new;
    pair_idx_d   = edge_seen ? pair_base + 2'd1 : pair_base;
    if (front_o.done) begin
      acc_d = '0;
    end else if (edge_seen) begin
      acc_d = acc_new;
    end else begin
      acc_d = acc_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q  <= '0;
      prev_q     <= 1'b0;
      pair_idx_q <= '0;
      acc_q      <= '0;
    end else if (step_i) begin
      silence_q  <= silence_d;
      prev_q     <= strobe_level_i;
      pair_idx_q <= pair_idx_d;
      acc_q      <= acc_d;
    end
  end

endmodule
`default_nettype wire

### sv/strobed_dibit_frame_receiver.sv
// Strobed dibit frame receiver. Each input item is one pin sample (strobe level and data
// pair); every strobe edge shifts a pair into a byte, and each finished byte is stored in a
// RING_DEPTH-entry ring memory. A byte equal to end_marker closes a frame: the length and
// XOR checksum are checked by walking the ring, and a good frame is replayed oldest byte
// first as a run of payload items; a good empty frame gives one empty item, and a frame
// with a length above MAX_PAYLOAD or a bad checksum gives one reject item. Any other
// finished byte is output as a byte item. After a finished byte no new item is accepted
// until its result is loaded into the output register, so an output stall holds the input.
// The frame walk is paced by the single read port of the ring memory (a read state and a
// wait state per entry, plus one output load per payload byte). After reset the ring is
// cleared, during which no item is accepted; configuration writes are taken at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module strobed_dibit_frame_receiver #(
  parameter int RING_DEPTH  = 128,
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [sdfr_pkg::DATA_W-1:0] cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        strobe_level_i,
  input  wire logic [1:0]                  data_pair_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       kind_o,
  output logic [sdfr_pkg::DATA_W-1:0]      value_o,
  output logic [sdfr_pkg::POS_W-1:0]       position_o,
  output logic                             last_o
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int OW = $clog2(MAX_PAYLOAD + 4);
  localparam logic [AW:0]   DEPTH_X = (AW+1)'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(RING_DEPTH - 1);
  localparam logic [sdfr_pkg::DATA_W-1:0] MAX_LEN = sdfr_pkg::DATA_W'(MAX_PAYLOAD);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEN_RD,
    ST_LEN_WT,
    ST_SUM_RD,
    ST_SUM_WT,
    ST_CHK_RD,
    ST_CHK_WT,
    ST_PAY_RD,
    ST_PAY_WT,
    ST_PUSH
  } state_e;

  state_e                      state_q;
  logic [sdfr_pkg::DATA_W-1:0] end_marker_q, silence_ticks_q;
  logic [AW-1:0]               wp_q, clr_q, wp_eff, wp_d;
  logic [CW-1:0]               len_q, cnt_q, idx_q;
  logic [sdfr_pkg::DATA_W-1:0] sum_q;
  sdfr_pkg::kind_e             pend_kind_q, out_kind_q;
  logic [sdfr_pkg::DATA_W-1:0] pend_value_q, out_value_q;
  logic [sdfr_pkg::POS_W-1:0]  pend_pos_q, out_pos_q;
  logic                        pend_last_q, pend_more_q, out_last_q, out_valid_q;

  sdfr_pkg::front_t            front;
  logic                        in_acc, out_free;
  logic                        ring_we, ring_re;
  logic [AW-1:0]               ring_waddr, ring_raddr;
  logic [sdfr_pkg::DATA_W-1:0] ring_wdata, ring_rdata;
  logic [OW-1:0]               rd_off;
  logic [AW:0]                 rd_sum;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign value_o     = out_value_q;
  assign position_o  = out_pos_q;
  assign last_o      = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_marker_q    <= sdfr_pkg::END_MARKER_RST;
      silence_ticks_q <= sdfr_pkg::SILENCE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdfr_pkg::CFG_END_MARKER:    end_marker_q    <= cfg_data_i;
        sdfr_pkg::CFG_SILENCE_TICKS: silence_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sdfr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (in_acc),
    .strobe_level_i  (strobe_level_i),
    .data_pair_i     (data_pair_i),
    .silence_ticks_i (silence_ticks_q),
    .front_o         (front)
  );

  always_comb begin
    wp_eff = front.resync ? '0 : wp_q;
    if (front.done) begin
      wp_d = (wp_eff == LAST_A) ? '0 : wp_eff + AW'(1);
    end else begin
      wp_d = wp_eff;
    end
  end

  always_comb begin
    unique case (state_q)
      ST_SUM_RD: rd_off = OW'(cnt_q) + OW'(3);
      ST_CHK_RD: rd_off = OW'(2);
      ST_PAY_RD: rd_off = OW'(len_q - idx_q) + OW'(3);
      default:   rd_off = OW'(3);
    endcase
    rd_sum     = {1'b0, wp_q} + DEPTH_X - (AW+1)'(rd_off);
    ring_raddr = (rd_sum >= DEPTH_X) ? AW'(rd_sum - DEPTH_X) : AW'(rd_sum);
    ring_re    = (state_q == ST_LEN_RD) || (state_q == ST_SUM_RD) ||
                 (state_q == ST_CHK_RD) || (state_q == ST_PAY_RD);
    ring_we    = (state_q == ST_CLEAR) || (in_acc && front.done);
    ring_waddr = (state_q == ST_CLEAR) ? clr_q : wp_eff;
    ring_wdata = (state_q == ST_CLEAR) ? '0 : front.data;
  end

  sdfr_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      wp_q         <= '0;
      len_q        <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      sum_q        <= '0;
      pend_kind_q  <= sdfr_pkg::KIND_BYTE;
      pend_value_q <= '0;
      pend_pos_q   <= '0;
      pend_last_q  <= 1'b0;
      pend_more_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= sdfr_pkg::KIND_BYTE;
      out_value_q  <= '0;
      out_pos_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= (clr_q == LAST_A) ? '0 : clr_q + AW'(1);
          if (clr_q == LAST_A) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            wp_q <= wp_d;
            if (front.done) begin
              if (front.data == end_marker_q) begin
                state_q <= ST_LEN_RD;
              end else begin
                pend_kind_q  <= sdfr_pkg::KIND_BYTE;
                pend_value_q <= front.data;
                pend_pos_q   <= '0;
                pend_last_q  <= 1'b1;
                pend_more_q  <= 1'b0;
                state_q      <= ST_PUSH;
              end
            end
          end
        end
        ST_LEN_RD: state_q <= ST_LEN_WT;
        ST_LEN_WT: begin
          if (ring_rdata > MAX_LEN) begin
            pend_kind_q  <= sdfr_pkg::KIND_REJECT;
            pend_value_q <= end_marker_q;
            pend_pos_q   <= '0;
            pend_last_q  <= 1'b1;
            pend_more_q  <= 1'b0;
            state_q      <= ST_PUSH;
          end else begin
            len_q   <= CW'(ring_rdata);
            cnt_q   <= CW'(ring_rdata);
            sum_q   <= '0;
            state_q <= ST_SUM_RD;
          end
        end
        ST_SUM_RD: state_q <= ST_SUM_WT;
        ST_SUM_WT: begin
          sum_q <= sum_q ^ ring_rdata;
          if (cnt_q == '0) begin
            state_q <= ST_CHK_RD;
          end else begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= ST_SUM_RD;
          end
        end
        ST_CHK_RD: state_q <= ST_CHK_WT;
        ST_CHK_WT: begin
          pend_value_q <= end_marker_q;
          pend_pos_q   <= '0;
          pend_last_q  <= 1'b1;
          pend_more_q  <= 1'b0;
          if (sum_q != ring_rdata) begin
            pend_kind_q <= sdfr_pkg::KIND_REJECT;
            state_q     <= ST_PUSH;
          end else if (len_q == '0) begin
            pend_kind_q <= sdfr_pkg::KIND_EMPTY;
            state_q     <= ST_PUSH;
          end else begin
            idx_q   <= '0;
            state_q <= ST_PAY_RD;
          end
        end
        ST_PAY_RD: state_q <= ST_PAY_WT;
        ST_PAY_WT: begin
          pend_kind_q  <= sdfr_pkg::KIND_PAYLOAD;
          pend_value_q <= ring_rdata;
          pend_pos_q   <= sdfr_pkg::POS_W'(idx_q);
          pend_last_q  <= ((idx_q + CW'(1)) == len_q);
          pend_more_q  <= ((idx_q + CW'(1)) != len_q);
          idx_q        <= idx_q + CW'(1);
          state_q      <= ST_PUSH;
        end
        ST_PUSH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= pend_kind_q;
            out_value_q <= pend_value_q;
            out_pos_q   <= pend_pos_q;
            out_last_q  <= pend_last_q;
            state_q     <= pend_more_q ? ST_PAY_RD : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_we && ring_re))
    else $error("ring read and write in the same cycle");

  a_pay_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAY_RD) |-> (idx_q < len_q) && (len_q != '0))
    else $error("payload index outside frame length");

  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q != sdfr_pkg::KIND_PAYLOAD)) |-> (out_pos_q == '0))
    else $error("nonzero position on a non-payload item");

  a_push_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> (pend_last_q != pend_more_q))
    else $error("pending item last and more flags disagree");

endmodule
`default_nettype wire
